FILE: rtl/toc_pkg.sv
// shared types and constants of the topological order checker
`default_nettype none

package toc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;

  localparam int VTX_W    = $clog2(MAX_VERTICES);
  localparam int NUM_W    = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_AW  = $clog2(MAX_EDGES);
  localparam int LINK_W   = $clog2(MAX_EDGES + 1);
  localparam int INDEG_W  = $clog2(MAX_EDGES + 1);

  localparam int IN_W  = 32;
  localparam int OUT_W = 8;

  localparam logic [LINK_W-1:0] LINK_NULL  = LINK_W'(MAX_EDGES);
  localparam logic [LINK_W-1:0] EDGE_FULL  = LINK_W'(MAX_EDGES);
  localparam logic [NUM_W-1:0]  NUM_MAX    = NUM_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_VISIT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_E_HEAD, S_E_RDDST, S_E_IND, S_V_CHK, S_V_WALK, S_V_EDGE, S_V_DEC, S_FINISH
  } state_e;

  typedef struct packed {
    logic [INDEG_W-1:0] indeg;
    logic               visited;
    logic [LINK_W-1:0]  head;
  } vtx_t;

  localparam vtx_t VTX_RESET = '{indeg: '0, visited: 1'b0, head: LINK_NULL};

  typedef struct packed {
    logic [VTX_W-1:0]  target;
    logic [LINK_W-1:0] next;
  } edge_t;

  typedef struct packed {
    logic             clr;
    logic             rd_en;
    logic [VTX_W-1:0] rd_addr;
    logic             wr_en;
    logic [VTX_W-1:0] wr_addr;
    vtx_t             wr_data;
  } vs_req_t;

endpackage

`default_nettype wire

FILE: rtl/toc_vertex_store.sv
// per-vertex store: in-degree, visited mark and list head, with valid bits
`default_nettype none

module toc_vertex_store
  import toc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire vs_req_t req_i,
  output vtx_t         rd_data_o
);

  vtx_t                    mem [MAX_VERTICES];
  vtx_t                    mem_q;
  logic [MAX_VERTICES-1:0] vld_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      mem_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? mem_q : VTX_RESET;

endmodule

`default_nettype wire

FILE: rtl/topological_order_checker.sv
// top level of the topological order checker
//
//  channel  | signals                              | beat
//  ---------+--------------------------------------+-------------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata[31:0]     | op, source, target, visited vertex
//  m_axis   | m_axis_tvalid/tready/tdata[7:0]      | status, order_ok, done_res
//  cfg      | cfg_valid_i/cfg_ready_o/cfg_data_i   | num_vertices, always ready
//
// clear, rejected and ignored items go straight to the result; an accepted edge reads and writes
// back the source entry, then the target entry; a visit that breaks the order stops at the check,
// and any other visit walks the out-edge list, one edge-list link per walk step.
// one item is worked at a time; the next is taken while a result waits in the output register.
// reset clears the vertex store at once through its valid bits; no clearing pass is needed.
// a stalled m_axis holds the result and the block stops after at most one more item.
`default_nettype none

module topological_order_checker
  import toc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // op[1:0] source[9:2] target[17:10] visited[25:18]
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // status[1:0] order_ok[2] done_res[3]
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [NUM_W-1:0] cfg_data_i
);

  state_e             state_q, state_d;
  logic [NUM_W-1:0]   num_q;
  logic [NUM_W-1:0]   lim;
  logic [VTX_W-1:0]   src_q, src_d, dst_q, dst_d;
  logic [LINK_W-1:0]  link_q, link_d;
  logic [LINK_W-1:0]  edge_count_q, edge_count_d;
  logic [NUM_W-1:0]   visit_count_q, visit_count_d;
  logic               failed_q, failed_d;
  status_e            status_q, status_d;
  logic               m_valid_q, m_valid_d;
  logic [OUT_W-1:0]   m_data_q, m_data_d;

  vs_req_t            vs_req;
  vtx_t               vs_rd;

  edge_t              edge_mem [MAX_EDGES];
  edge_t              edge_q;
  logic               edge_we, edge_re;
  logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
  edge_t              edge_wdata;

  logic               in_acc;
  op_e                in_op;
  logic [VTX_W-1:0]   in_src, in_dst, in_vis;

  assign in_op  = op_e'(s_axis_tdata[1:0]);
  assign in_src = s_axis_tdata[9:2];
  assign in_dst = s_axis_tdata[17:10];
  assign in_vis = s_axis_tdata[25:18];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    if (num_q == '0) begin
      lim = NUM_W'(1);
    end else if (num_q > NUM_MAX) begin
      lim = NUM_MAX;
    end else begin
      lim = num_q;
    end
  end

  toc_vertex_store u_vstore (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (vs_req),
    .rd_data_o(vs_rd)
  );

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_q <= edge_mem[edge_raddr];
    end
  end

  always_comb begin
    state_d       = state_q;
    src_d         = src_q;
    dst_d         = dst_q;
    link_d        = link_q;
    edge_count_d  = edge_count_q;
    visit_count_d = visit_count_q;
    failed_d      = failed_q;
    status_d      = status_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    vs_req        = '0;
    edge_we       = 1'b0;
    edge_re       = 1'b0;
    edge_waddr    = edge_count_q[EDGE_AW-1:0];
    edge_raddr    = link_q[EDGE_AW-1:0];
    edge_wdata    = '{target: dst_q, next: vs_rd.head};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          src_d    = (in_op == OP_VISIT) ? in_vis : in_src;
          dst_d    = in_dst;
          status_d = ST_OK;
          state_d  = S_FINISH;
          case (in_op)
            OP_CLEAR: begin
              vs_req.clr    = 1'b1;
              edge_count_d  = '0;
              visit_count_d = '0;
              failed_d      = 1'b0;
            end
            OP_EDGE: begin
              if ({1'b0, in_src} >= lim || {1'b0, in_dst} >= lim) begin
                status_d = ST_RANGE;
              end else if (edge_count_q == EDGE_FULL) begin
                status_d = ST_FULL;
              end else begin
                vs_req.rd_en   = 1'b1;
                vs_req.rd_addr = in_src;
                state_d        = S_E_HEAD;
              end
            end
            OP_VISIT: begin
              if ({1'b0, in_vis} >= lim) begin
                status_d = ST_RANGE;
              end else if (visit_count_q < lim) begin
                visit_count_d = visit_count_q + NUM_W'(1);
                if (!failed_q) begin
                  vs_req.rd_en   = 1'b1;
                  vs_req.rd_addr = in_vis;
                  state_d        = S_V_CHK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_E_HEAD: begin
        edge_we        = 1'b1;
        vs_req.wr_en   = 1'b1;
        vs_req.wr_addr = src_q;
        vs_req.wr_data = '{indeg: vs_rd.indeg, visited: vs_rd.visited, head: edge_count_q};
        edge_count_d   = edge_count_q + LINK_W'(1);
        state_d        = S_E_RDDST;
      end
      S_E_RDDST: begin
        vs_req.rd_en   = 1'b1;
        vs_req.rd_addr = dst_q;
        state_d        = S_E_IND;
      end
      S_E_IND: begin
        vs_req.wr_en   = 1'b1;
        vs_req.wr_addr = dst_q;
        vs_req.wr_data = '{indeg: vs_rd.indeg + INDEG_W'(1), visited: vs_rd.visited,
                           head: vs_rd.head};
        state_d        = S_FINISH;
      end
      S_V_CHK: begin
        if (vs_rd.indeg != '0 || vs_rd.visited) begin
          failed_d = 1'b1;
          state_d  = S_FINISH;
        end else begin
          vs_req.wr_en   = 1'b1;
          vs_req.wr_addr = src_q;
          vs_req.wr_data = '{indeg: vs_rd.indeg, visited: 1'b1, head: vs_rd.head};
          link_d         = vs_rd.head;
          state_d        = S_V_WALK;
        end
      end
      S_V_WALK: begin
        if (link_q < edge_count_q) begin
          edge_re = 1'b1;
          state_d = S_V_EDGE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_V_EDGE: begin
        vs_req.rd_en   = 1'b1;
        vs_req.rd_addr = edge_q.target;
        dst_d          = edge_q.target;
        link_d         = edge_q.next;
        state_d        = S_V_DEC;
      end
      S_V_DEC: begin
        if (vs_rd.indeg != '0) begin
          vs_req.wr_en   = 1'b1;
          vs_req.wr_addr = dst_q;
          vs_req.wr_data = '{indeg: vs_rd.indeg - INDEG_W'(1), visited: vs_rd.visited,
                             head: vs_rd.head};
        end
        state_d = S_V_WALK;
      end
      S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0, (visit_count_q >= lim), !failed_q, status_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      num_q         <= NUM_W'(1);
      edge_count_q  <= '0;
      visit_count_q <= '0;
      failed_q      <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      edge_count_q  <= edge_count_d;
      visit_count_q <= visit_count_d;
      failed_q      <= failed_d;
      m_valid_q     <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    link_q   <= link_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
  end

  // edge memory never fills past its depth
  a_edge_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_count_q <= EDGE_FULL)
    else $error("edge count beyond memory depth");

  // a clear empties every counter and the failure flag
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == OP_CLEAR) |=>
      (edge_count_q == '0 && visit_count_q == '0 && !failed_q))
    else $error("clear left state behind");

  // a broken order stays broken until a clear
  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !(in_acc && in_op == OP_CLEAR)) |=> failed_q)
    else $error("order failure dropped without clear");

  // the list walk only follows links to written edges
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_V_WALK && edge_re) |-> (link_q < EDGE_FULL))
    else $error("list walk read beyond edge memory");

endmodule

`default_nettype wire

FILE: tb/sv/toc_checker.sv
// checker that mirrors the vertex, edge and visit stores and compares every result beat
module toc_checker
  import toc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [IN_W-1:0]  in_data_i,   // op[1:0] source[9:2] target[17:10] visited[25:18]
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [OUT_W-1:0] out_data_i,  // status[1:0] order_ok[2] done_res[3]
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [NUM_W-1:0] cfg_data_i,
  output int               mismatches_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e status;
    logic    order_ok;
    logic    done;
  } verdict_t;

  verdict_t           pending_verdicts[$];
  logic [NUM_W-1:0]   vertex_count = NUM_W'(1);
  logic [INDEG_W-1:0] indeg [MAX_VERTICES];
  logic               visited [MAX_VERTICES];
  logic [LINK_W-1:0]  head [MAX_VERTICES];
  logic [VTX_W-1:0]   edge_tgt [MAX_EDGES];
  logic [LINK_W-1:0]  edge_nxt [MAX_EDGES];
  logic [LINK_W-1:0]  edge_count;
  logic [NUM_W-1:0]   visit_count;
  logic               order_broken;
  int                 mismatches = 0;

  function automatic int vertex_limit();
    if (vertex_count == 0) return 1;
    if (vertex_count > MAX_VERTICES) return MAX_VERTICES;
    return int'(vertex_count);
  endfunction

  function automatic void empty_graph();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      indeg[i]   = '0;
      visited[i] = 1'b0;
      head[i]    = LINK_NULL;
    end
    edge_count   = '0;
    visit_count  = '0;
    order_broken = 1'b0;
  endfunction

  function automatic verdict_t apply_graph_item(logic [IN_W-1:0] beat);
    logic [1:0]        op;
    logic [VTX_W-1:0]  src;
    logic [VTX_W-1:0]  dst;
    logic [VTX_W-1:0]  vis;
    logic [VTX_W-1:0]  succ;
    logic [LINK_W-1:0] link;
    int                lim;
    verdict_t          v;
    op  = beat[1:0];
    src = beat[9:2];
    dst = beat[17:10];
    vis = beat[25:18];
    lim = vertex_limit();
    v.status = ST_OK;
    case (op)
      OP_CLEAR: empty_graph();
      OP_EDGE: begin
        if (src >= lim || dst >= lim) begin
          v.status = ST_RANGE;
        end else if (edge_count >= MAX_EDGES) begin
          v.status = ST_FULL;
        end else begin
          edge_tgt[edge_count[EDGE_AW-1:0]] = dst;
          edge_nxt[edge_count[EDGE_AW-1:0]] = head[src];
          head[src] = edge_count;
          edge_count++;
          indeg[dst]++;
        end
      end
      OP_VISIT: begin
        if (vis >= lim) begin
          v.status = ST_RANGE;
        end else if (visit_count < lim) begin
          visit_count++;
          if (!order_broken) begin
            if (indeg[vis] != 0 || visited[vis]) begin
              order_broken = 1'b1;
            end else begin
              visited[vis] = 1'b1;
              link = head[vis];
              while (link < edge_count) begin
                succ = edge_tgt[link[EDGE_AW-1:0]];
                if (indeg[succ] != 0) indeg[succ]--;
                link = edge_nxt[link[EDGE_AW-1:0]];
              end
            end
          end
        end
      end
      default: ;
    endcase
    v.order_ok = !order_broken;
    v.done     = (visit_count >= lim);
    return v;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("toc_checker: %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t want;
    if (!rst_ni) begin
      vertex_count = NUM_W'(1);
      empty_graph();
      pending_verdicts.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) vertex_count = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          note_mismatch($sformatf("result beat %h with nothing outstanding", out_data_i));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_data_i[1:0] != want.status)
            note_mismatch($sformatf("status: expected %0d, got %0d",
                                    want.status, out_data_i[1:0]));
          if (out_data_i[2] != want.order_ok)
            note_mismatch($sformatf("order_ok: expected %0b, got %0b",
                                    want.order_ok, out_data_i[2]));
          if (out_data_i[3] != want.done)
            note_mismatch($sformatf("done_res: expected %0b, got %0b",
                                    want.done, out_data_i[3]));
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_graph_item(in_data_i);
        pending_verdicts = {pending_verdicts, want};
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= pending_verdicts.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// testbench top: drives graph, edge and visit beats and vertex counts, and gives the verdict
module tb_top;
  import toc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT     = 1_500_000;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         PHASE_BEATS     = 30;
  localparam logic [1:0] OP_UNUSED       = 2'd3;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [NUM_W-1:0] cfg_data_i    = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int cycles         = 0;
  int beats_sent     = 0;
  int graph_size     = 1;

  topological_order_checker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  toc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  initial forever begin
    @(posedge clk_i);
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic put_beat(input logic [1:0] op, input logic [VTX_W-1:0] src,
                          input logic [VTX_W-1:0] dst, input logic [VTX_W-1:0] vis);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({vis, dst, src, op});
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic put_edge(input int src, input int dst);
    put_beat(OP_EDGE, VTX_W'(src), VTX_W'(dst), VTX_W'($urandom_range(255)));
  endtask

  task automatic put_visit(input int vtx);
    put_beat(OP_VISIT, VTX_W'($urandom_range(255)), VTX_W'($urandom_range(255)), VTX_W'(vtx));
  endtask

  task automatic put_clear();
    put_beat(OP_CLEAR, VTX_W'($urandom_range(255)), VTX_W'($urandom_range(255)),
             VTX_W'($urandom_range(255)));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic set_vertex_count(input int value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= NUM_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    graph_size = (value == 0) ? 1 : (value > MAX_VERTICES) ? MAX_VERTICES : value;
  endtask

  // random DAG consistent with a shuffled order, then that order visited; noisy runs mix in stray beats
  task automatic run_graph(input bit noisy);
    int order[$];
    int n;
    int k;
    int tmp;
    int a;
    int b;
    n = graph_size;
    for (int i = 0; i < n; i++) order = {order, i};
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    put_clear();
    repeat ($urandom_range(n < 16 ? 2 * n : n / 2)) begin
      if (noisy && $urandom_range(9) == 0) begin
        put_edge($urandom_range(255), $urandom_range(255));
      end else if (n > 1) begin
        a = $urandom_range(n - 2);
        b = $urandom_range(n - 1, a + 1);
        put_edge(order[a], order[b]);
      end
    end
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        case ($urandom_range(3))
          0: put_visit($urandom_range(255));
          1: put_visit(order[$urandom_range(i)]);
          2: put_beat(OP_UNUSED, VTX_W'($urandom_range(255)), VTX_W'($urandom_range(255)),
                      VTX_W'($urandom_range(255)));
          default: put_clear();
        endcase
      end
      put_visit(order[i]);
    end
    repeat ($urandom_range(2)) put_visit($urandom_range(n - 1));
  endtask

  initial begin
    int phase_count[8] = '{5, 12, 2, 256, 3, 511, 40, 0};
    int phase_idle[8]  = '{0, 85, 0, 29, 0, 85, 0, 29};
    int phase_stall[8] = '{0, 0, 85, 29, 0, 0, 85, 29};
    int start;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one vertex after reset
    put_visit(0);
    put_visit(0);
    put_visit(255);
    put_beat(OP_UNUSED, 8'hff, 8'hff, 8'hff);
    put_clear();
    put_edge(0, 0);
    put_visit(0);

    // zero counts as one vertex
    set_vertex_count(0);
    put_clear();
    put_edge(0, 1);
    put_edge(255, 0);
    put_visit(0);

    set_vertex_count(MAX_VERTICES);
    put_clear();
    put_edge(255, 0);
    put_edge(0, 170);
    put_visit(0);
    put_visit(255);
    put_clear();
    put_edge(255, 0);
    put_visit(255);
    put_visit(0);
    put_visit(0);

    // above the store size clamps to the store size
    set_vertex_count(511);
    put_clear();
    put_edge(255, 255);
    put_visit(255);

    for (int p = 0; p < 8; p++) begin
      set_vertex_count(phase_count[p]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      if (phase_idle[p] == 0 && phase_stall[p] == 0) hold_cycles = HOLD_OFF_CYCLES;
      if (p == 2) begin
        // fill the edge memory from one vertex, then walk the whole list
        put_clear();
        repeat (MAX_EDGES) put_edge(0, 1);
        put_edge(1, 0);
        put_edge(0, 200);
        put_visit(0);
        put_visit(1);
        put_edge(1, 0);
      end
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        run_graph($urandom_range(9) < 3);
        if ($urandom_range(4) == 0) settle();
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
